// File: sv/bbc_pkg.sv
// Package for the block buffer cache tracker.
// Holds the request and response payload types and the command and status codes.
// Depends on nothing; the tracker and its testbench use it.
`default_nettype none

package bbc_pkg;

    // Command codes carried in the request.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes returned in the response.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    // Fixed field widths of the payload.
    localparam int DEV_BITS  = 8;
    localparam int BLK_BITS  = 32;
    localparam int SLOT_BITS = 5;

    // One request transfer.
    typedef struct packed {
        logic                 cmd;
        logic [DEV_BITS-1:0]  device_id;
        logic [BLK_BITS-1:0]  block_number;
        logic [SLOT_BITS-1:0] release_slot;
    } req_t;

    // One response transfer.
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic                 hit;
        logic                 fill_needed;
        logic [1:0]           status;
    } rsp_t;

endpackage

`default_nettype wire

// File: sv/block_buffer_cache_tracker.sv
// Block buffer cache tracker: a table of buffers tagged by device and block number.
// An acquire reads the table RAM once per entry, then decides and writes back.
// One item is in work at a time, and a new request is taken while a response still waits.
// Reset clears the per-entry written bits, so every entry reads as zero until written.
`default_nettype none

module block_buffer_cache_tracker #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire bbc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output bbc_pkg::rsp_t      rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CB = COUNT_BITS;
    localparam int DB = bbc_pkg::DEV_BITS;
    localparam int BB = bbc_pkg::BLK_BITS;
    localparam int SB = bbc_pkg::SLOT_BITS;
    // Entry word: device tag, block tag, reference count, valid mark (bit 0).
    localparam int W       = DB + BB + CB + 1;
    localparam int CNT_LO  = 1;
    localparam int BLK_LO  = CB + 1;
    localparam int DEV_LO  = CB + BB + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_REL  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    bbc_pkg::req_t   req_reg, req_next;
    logic            rel_ok_reg, rel_ok_next;
    logic [IW:0]     scan_idx_reg, scan_idx_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic            hit_found_reg, hit_found_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;
    logic [CB-1:0]   hit_cnt_reg, hit_cnt_next;
    logic            hit_vld_reg, hit_vld_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0] written_reg, written_next;
    bbc_pkg::rsp_t   res_reg, res_next;
    logic            rsp_valid_reg, rsp_valid_next;
    bbc_pkg::rsp_t   rsp_reg, rsp_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [W-1:0]    ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [W-1:0]    ram_rdata;

    logic [W-1:0]    entry;
    logic [DB-1:0]   e_dev;
    logic [BB-1:0]   e_blk;
    logic [CB-1:0]   e_cnt;
    logic            e_vld;
    logic [IW+SB-1:0] rel_ext;
    logic [IW-1:0]   rel_idx;
    logic            rel_in_range;
    logic [IW+SB-1:0] hit_ext;
    logic [IW+SB-1:0] free_ext;
    logic            req_xfer;

    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    bbc_ram #(
        .WIDTH (W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written reads as all zero.
    assign entry = written_reg[rd_idx_reg] ? ram_rdata : '0;
    assign e_dev = entry[DEV_LO +: DB];
    assign e_blk = entry[BLK_LO +: BB];
    assign e_cnt = entry[CNT_LO +: CB];
    assign e_vld = entry[0];

    // Release slot mapped onto the table index range.
    assign rel_ext      = {{IW{1'b0}}, req.release_slot};
    assign rel_idx      = rel_ext[IW-1:0];
    assign rel_in_range = rel_ext < (IW + SB)'(ENTRIES);

    assign hit_ext  = {{SB{1'b0}}, hit_idx_reg};
    assign free_ext = {{SB{1'b0}}, free_idx_reg};

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;

    // Read address: first read issued on the request transfer, then the scan counter.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            ram_raddr = (req.cmd == bbc_pkg::CMD_RELEASE) ? rel_idx : '0;
        end
        else
        begin
            ram_raddr = scan_idx_reg[IW-1:0];
        end
    end

    // Control sequence, table update and result formation.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rel_ok_next     = rel_ok_reg;
        scan_idx_next   = scan_idx_reg;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_vld_next    = hit_vld_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        written_next    = written_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;

        // The waiting response leaves on its transfer.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    req_next        = req;
                    rel_ok_next     = rel_in_range;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (req.cmd == bbc_pkg::CMD_RELEASE)
                    begin
                        rd_idx_next = rel_idx;
                        state_next  = S_REL;
                    end
                    else
                    begin
                        rd_idx_next   = '0;
                        scan_idx_next = (IW + 1)'(1);
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle against the requested tag.
                if (!hit_found_reg && e_dev == req_reg.device_id
                    && e_blk == req_reg.block_number)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_cnt_next   = e_cnt;
                    hit_vld_next   = e_vld;
                end
                if (!free_found_reg && e_cnt == '0)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (scan_idx_reg != (IW + 1)'(ENTRIES))
                begin
                    rd_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + (IW + 1)'(1);
                end
                else
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                ram_wdata[DEV_LO +: DB] = req_reg.device_id;
                ram_wdata[BLK_LO +: BB] = req_reg.block_number;
                ram_wdata[0]            = 1'b1;
                if (hit_found_reg)
                begin
                    res_next.slot = hit_ext[SB-1:0];
                    res_next.hit  = 1'b1;
                    if (hit_cnt_reg == COUNT_MAX)
                    begin
                        res_next.fill_needed = 1'b0;
                        res_next.status      = bbc_pkg::ST_SATURATED;
                    end
                    else
                    begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = hit_idx_reg;
                        ram_wdata[CNT_LO +: CB]   = hit_cnt_reg + CB'(1);
                        res_next.fill_needed      = !hit_vld_reg;
                        res_next.status           = bbc_pkg::ST_OK;
                    end
                end
                else if (free_found_reg)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = free_idx_reg;
                    ram_wdata[CNT_LO +: CB] = CB'(1);
                    res_next.slot           = free_ext[SB-1:0];
                    res_next.hit            = 1'b0;
                    res_next.fill_needed    = 1'b1;
                    res_next.status         = bbc_pkg::ST_OK;
                end
                else
                begin
                    res_next.slot        = '0;
                    res_next.hit         = 1'b0;
                    res_next.fill_needed = 1'b0;
                    res_next.status      = bbc_pkg::ST_FULL;
                end
                if (ram_we)
                begin
                    written_next[ram_waddr] = 1'b1;
                end
                state_next = S_FIN;
            end

            S_REL:
            begin
                res_next.slot        = req_reg.release_slot;
                res_next.hit         = 1'b0;
                res_next.fill_needed = 1'b0;
                if (!rel_ok_reg || e_cnt == '0)
                begin
                    res_next.status = bbc_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = rd_idx_reg;
                    ram_wdata               = entry;
                    ram_wdata[CNT_LO +: CB] = e_cnt - CB'(1);
                    written_next[rd_idx_reg] = 1'b1;
                    res_next.status         = bbc_pkg::ST_OK;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // Hand the result to the output register once it is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            written_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            written_reg    <= written_next;
            rsp_valid_reg  <= rsp_valid_next;
            scan_idx_reg   <= scan_idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rel_ok_reg   <= rel_ok_next;
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        hit_vld_reg  <= hit_vld_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The table is written only in the decide and release update cycles.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DEC || state_reg == S_REL))
        else $error("table written outside an update cycle");

    // The scan counter never runs past the table.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= (IW + 1)'(ENTRIES))
        else $error("scan index beyond table");

    // A hit is only ever reported as ok or saturated.
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit |-> (rsp.status == bbc_pkg::ST_OK
                                  || rsp.status == bbc_pkg::ST_SATURATED))
        else $error("hit with bad status");

    // A fill request always comes with ok status.
    a_fill_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fill_needed |-> rsp.status == bbc_pkg::ST_OK)
        else $error("fill requested with error status");

    // A request transfer starts either a scan or a release read.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == S_SCAN || state_reg == S_REL))
        else $error("request transfer did not start work");

endmodule

`default_nettype wire

// File: sv/bbc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Used for the tag, count and valid table of the block buffer cache tracker.
// Depends on nothing.
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: verif/block_buffer_cache_tracker_test.sv
// Self-checking testbench for the block buffer cache tracker.
// Predicts every response from its own copy of the buffer table and checks each transfer.
// Depends on bbc_pkg and block_buffer_cache_tracker.
`default_nettype none

module block_buffer_cache_tracker_test;

    localparam int ENTRIES    = 32;
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int RANDOM_ITEMS = 650;
    localparam int TAG_POOL     = 40;

    // Patterns the response side cycles through.
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} stall_mode_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    bbc_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    bbc_pkg::rsp_t rsp;

    // Model of the buffer table.
    logic [bbc_pkg::DEV_BITS-1:0] tag_dev   [ENTRIES];
    logic [bbc_pkg::BLK_BITS-1:0] tag_blk   [ENTRIES];
    logic [COUNT_BITS-1:0]        use_count [ENTRIES];
    logic                         filled    [ENTRIES];

    // Responses predicted but not yet seen.
    bbc_pkg::rsp_t awaited_rsp[$];
    bbc_pkg::rsp_t want_rsp;
    int   error_count = 0;
    int   burst_left  = 0;

    block_buffer_cache_tracker #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #6000000;
        $display("block_buffer_cache_tracker_test: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one request to the table model and return the response it causes.
    function automatic bbc_pkg::rsp_t buffer_table_step(input bbc_pkg::req_t r);
        bbc_pkg::rsp_t o;
        int   match;
        int   free_slot;
        o = '0;
        match = -1;
        free_slot = -1;
        if (r.cmd == bbc_pkg::CMD_ACQUIRE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match < 0 && tag_dev[i] == r.device_id && tag_blk[i] == r.block_number)
                    match = i;
                if (free_slot < 0 && use_count[i] == '0)
                    free_slot = i;
            end
            if (match >= 0)
            begin
                // A tag hit counts even when the entry holds no references.
                o.slot = bbc_pkg::SLOT_BITS'(match);
                o.hit  = 1'b1;
                if (use_count[match] == COUNT_MAX)
                    o.status = bbc_pkg::ST_SATURATED;
                else
                begin
                    use_count[match]++;
                    o.fill_needed = !filled[match];
                    filled[match] = 1'b1;
                    o.status = bbc_pkg::ST_OK;
                end
            end
            else if (free_slot >= 0)
            begin
                tag_dev[free_slot]   = r.device_id;
                tag_blk[free_slot]   = r.block_number;
                use_count[free_slot] = COUNT_BITS'(1);
                filled[free_slot]    = 1'b1;
                o.slot        = bbc_pkg::SLOT_BITS'(free_slot);
                o.fill_needed = 1'b1;
                o.status      = bbc_pkg::ST_OK;
            end
            else
                o.status = bbc_pkg::ST_FULL;
        end
        else
        begin
            o.slot = r.release_slot;
            if (r.release_slot >= ENTRIES || use_count[r.release_slot] == '0)
                o.status = bbc_pkg::ST_UNDERFLOW;
            else
            begin
                use_count[r.release_slot]--;
                o.status = bbc_pkg::ST_OK;
            end
        end
        return o;
    endfunction

    // Request builders; the unused fields carry random bits.
    function automatic bbc_pkg::req_t acquire_req(input logic [bbc_pkg::DEV_BITS-1:0] dev,
                                                  input logic [bbc_pkg::BLK_BITS-1:0] blk);
        bbc_pkg::req_t r;
        r.cmd          = bbc_pkg::CMD_ACQUIRE;
        r.device_id    = dev;
        r.block_number = blk;
        r.release_slot = bbc_pkg::SLOT_BITS'($urandom);
        return r;
    endfunction

    function automatic bbc_pkg::req_t release_req(input logic [bbc_pkg::SLOT_BITS-1:0] s);
        bbc_pkg::req_t r;
        r.cmd          = bbc_pkg::CMD_RELEASE;
        r.device_id    = bbc_pkg::DEV_BITS'($urandom);
        r.block_number = $urandom;
        r.release_slot = s;
        return r;
    endfunction

    // Send one request in bursts with random gaps, then record its prediction.
    task automatic send_req(input bbc_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        awaited_rsp.push_back(buffer_table_step(r));
    endtask

    // Drop every reference still held so the table has free entries again.
    task automatic drain_table();
        for (int i = 0; i < ENTRIES; i++)
            while (use_count[i] != '0)
                send_req(release_req(bbc_pkg::SLOT_BITS'(i)));
    endtask

    // Tags start out as (0,0), so the first acquire of that tag hits entry 0.
    task automatic test_startup_tag();
        send_req(acquire_req('0, '0));
        send_req(acquire_req('0, '0));
        send_req(release_req(bbc_pkg::SLOT_BITS'(0)));
        send_req(release_req(bbc_pkg::SLOT_BITS'(0)));
        send_req(release_req(bbc_pkg::SLOT_BITS'(0)));
        send_req(release_req(bbc_pkg::SLOT_BITS'(ENTRIES - 1)));
    endtask

    // Field extremes, and reuse of an unreferenced entry through its tag.
    task automatic test_field_extremes();
        send_req(acquire_req('1, '1));
        send_req(acquire_req('0, '0));
        send_req(release_req(bbc_pkg::SLOT_BITS'(0)));
        send_req(acquire_req('1, '1));
        send_req(acquire_req(8'hA5, 32'h5A5A_A5A5));
        send_req(acquire_req(8'h5A, 32'hA5A5_5A5A));
        send_req(release_req(bbc_pkg::SLOT_BITS'(ENTRIES - 1)));
        send_req(release_req(bbc_pkg::SLOT_BITS'(1)));
        drain_table();
    endtask

    // Fill every entry with a distinct tag, then ask for one more.
    task automatic test_full_table();
        logic [bbc_pkg::BLK_BITS-1:0] base;
        base = $urandom;
        for (int i = 0; i < ENTRIES; i++)
            send_req(acquire_req(bbc_pkg::DEV_BITS'(i + 1),
                                 bbc_pkg::BLK_BITS'(base + i)));
        send_req(acquire_req(bbc_pkg::DEV_BITS'(ENTRIES + 1), base));
        send_req(acquire_req(bbc_pkg::DEV_BITS'(3), bbc_pkg::BLK_BITS'(base + 2)));
        drain_table();
    endtask

    // Hammer one tag until its count saturates, then step back below the top.
    task automatic test_count_saturation();
        logic [bbc_pkg::DEV_BITS-1:0] dev;
        logic [bbc_pkg::BLK_BITS-1:0] blk;
        dev = bbc_pkg::DEV_BITS'($urandom);
        blk = $urandom;
        for (int i = 0; i < int'(COUNT_MAX) + 3; i++)
            send_req(acquire_req(dev, blk));
        send_req(release_req(bbc_pkg::SLOT_BITS'(0)));
        send_req(acquire_req(dev, blk));
        send_req(acquire_req(dev, blk));
        drain_table();
    endtask

    // Random traffic over a tag pool a bit larger than the table, in phases of
    // varying acquire pressure so the table both fills up and empties out.
    task automatic test_random_mix();
        logic [bbc_pkg::DEV_BITS-1:0] pool_dev [TAG_POOL];
        logic [bbc_pkg::BLK_BITS-1:0] pool_blk [TAG_POOL];
        int held[$];
        int acquire_pct;
        int pick;
        int roll;
        for (int i = 0; i < TAG_POOL; i++)
        begin
            pool_dev[i] = bbc_pkg::DEV_BITS'($urandom);
            pool_blk[i] = $urandom;
        end
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = '1;
        pool_blk[1] = '1;
        acquire_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 125 == 0)
                acquire_pct = $urandom_range(25, 80);
            roll = $urandom_range(0, 99);
            if (roll < acquire_pct)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_req(acquire_req(bbc_pkg::DEV_BITS'($urandom), $urandom));
                else
                begin
                    pick = $urandom_range(0, TAG_POOL - 1);
                    send_req(acquire_req(pool_dev[pick], pool_blk[pick]));
                end
            end
            else
            begin
                held.delete();
                for (int i = 0; i < ENTRIES; i++)
                    if (use_count[i] != '0)
                        held.push_back(i);
                if (held.size() > 0 && $urandom_range(0, 4) != 0)
                    send_req(release_req(
                        bbc_pkg::SLOT_BITS'(held[$urandom_range(0, held.size() - 1)])));
                else
                    send_req(release_req(bbc_pkg::SLOT_BITS'($urandom)));
            end
        end
    endtask

    // Response side stalls on its own pattern, changing mode at random intervals.
    initial
    begin
        stall_mode_t mode;
        int          tick;
        rsp_ready = 1'b0;
        tick = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            repeat ($urandom_range(8, 64))
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    READY_ALWAYS: rsp_ready <= 1'b1;
                    READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: rsp_ready <= (tick % 4 == 0);
                    default:      rsp_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each response transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch($sformatf("response with nothing awaited: %p", rsp));
            else
            begin
                want_rsp = awaited_rsp.pop_front();
                if (rsp.slot !== want_rsp.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", rsp.slot, want_rsp.slot));
                if (rsp.hit !== want_rsp.hit)
                    report_mismatch($sformatf("hit %0b, want %0b", rsp.hit, want_rsp.hit));
                if (rsp.fill_needed !== want_rsp.fill_needed)
                    report_mismatch($sformatf("fill_needed %0b, want %0b",
                                              rsp.fill_needed, want_rsp.fill_needed));
                if (rsp.status !== want_rsp.status)
                    report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                              rsp.status, want_rsp.status, want_rsp.slot));
            end
        end
    end

    // Reset, run each test in turn, then wait out the last responses.
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tag_dev[i]   = '0;
            tag_blk[i]   = '0;
            use_count[i] = '0;
            filled[i]    = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_startup_tag();
        test_field_extremes();
        test_full_table();
        test_count_saturation();
        test_random_mix();

        @(negedge clk);
        req_valid <= 1'b0;
        wait (awaited_rsp.size() == 0);
        repeat (ENTRIES + 10) @(posedge clk);
        if (awaited_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
        if (error_count == 0)
            $display("block_buffer_cache_tracker_test: clean");
        else
            $display("block_buffer_cache_tracker_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
